@@ design/dtti_pkg.sv @@
`default_nettype none

package dtti_pkg;

  localparam int unsigned OffsetWidth = 16;
  localparam logic [OffsetWidth-1:0] OffsetMax = {OffsetWidth{1'b1}};

  localparam logic [1:0] PhIdle   = 2'd0;
  localparam logic [1:0] PhLead   = 2'd1;
  localparam logic [1:0] PhDigits = 2'd2;

  localparam logic [1:0] StOk        = 2'd0;
  localparam logic [1:0] StRange     = 2'd1;
  localparam logic [1:0] StMalformed = 2'd2;

  localparam logic [1:0] ModeS32      = 2'd0;
  localparam logic [1:0] ModeU32      = 2'd1;
  localparam logic [1:0] ModeS64      = 2'd2;
  localparam logic [1:0] ModeS64Alias = 2'd3;

  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharMinus = 8'h2D;

  localparam logic [63:0] Int32Max  = 64'h0000_0000_7FFF_FFFF;
  localparam logic [63:0] Int32Min  = 64'h0000_0000_8000_0000;
  localparam logic [63:0] Uint32Max = 64'h0000_0000_FFFF_FFFF;
  localparam logic [63:0] Int64Max  = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] Int64Min  = 64'h8000_0000_0000_0000;

endpackage

`default_nettype wire

@@ design/decimal_text_to_integer.sv @@
// Decimal text to integer converter.
// Characters of a string arrive on the input request channel (in_valid_i,
// in_ready_o, ch_i, first_i), one per cycle if ready; first_i marks the first
// character of a new string. Leading whitespace and one minus sign are taken,
// then decimal digits. The first character after the digits ends the number
// and yields one result request (out_valid_o, out_ready_i, value_o, status_o,
// end_offset_o). A string without digits, or with whitespace or a second
// sign after the minus sign, yields a malformed result.
// result_mode_i is written while result_mode_we_i is high and selects signed
// 32-bit, unsigned 32-bit or signed 64-bit conversion (code three acts as
// signed 64-bit). It should only change while no string is being parsed.
// A result request is registered: its ending character waits in the input
// register, and the result register loads as that character advances. The
// block takes one character per cycle while the result is not stalled; the
// digit step (a shift-add by ten and a compare against the range limit) sits
// between the input register and the parser state. When the receiver stalls,
// the result register holds its request and the input register fills;
// in_ready_o then drops until the result is taken. Reset clears the parser to
// idle, the mode to signed 32-bit and both registers to empty.
`default_nettype none

module decimal_text_to_integer (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             result_mode_we_i,
  input  wire logic [1:0]                       result_mode_i,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic [7:0]                       ch_i,
  input  wire logic                             first_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic [63:0]                           value_o,
  output logic [1:0]                            status_o,
  output logic [dtti_pkg::OffsetWidth-1:0]      end_offset_o
);

  logic [1:0]                        mode_q;
  logic                              in_valid_q;
  logic [7:0]                        ch_q;
  logic                              first_q;
  logic [1:0]                        phase_q, phase_d;
  logic                              neg_q, neg_d;
  logic [63:0]                       mag_q, mag_d;
  logic [dtti_pkg::OffsetWidth-1:0]  cons_q, cons_d;
  logic                              ovf_q, ovf_d;
  logic                              out_valid_q;
  logic [63:0]                       value_q, value_d;
  logic [1:0]                        status_q, status_d;
  logic [dtti_pkg::OffsetWidth-1:0]  offset_q, offset_d;
  logic                              emit;
  logic                              advance;

  logic [1:0]                        ph;
  logic                              neg;
  logic [63:0]                       mag;
  logic [dtti_pkg::OffsetWidth-1:0]  cons;
  logic [dtti_pkg::OffsetWidth-1:0]  cons_inc;
  logic                              ovf;
  logic                              is_digit;
  logic                              is_space;
  logic [63:0]                       cap;
  logic [67:0]                       prod;
  logic                              prod_big;
  logic [63:0]                       neg_mag;
  logic [63:0]                       final_value;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_comb begin
    ph   = first_q ? dtti_pkg::PhLead : phase_q;
    neg  = first_q ? 1'b0 : neg_q;
    mag  = first_q ? 64'd0 : mag_q;
    cons = first_q ? '0 : cons_q;
    ovf  = first_q ? 1'b0 : ovf_q;

    is_digit = (ch_q >= dtti_pkg::CharZero) && (ch_q <= dtti_pkg::CharNine);
    is_space = (ch_q inside {8'h20, [8'h09:8'h0D]});
    cons_inc = (cons == dtti_pkg::OffsetMax) ? cons : cons + 1'b1;

    case (mode_q)
      dtti_pkg::ModeS32: cap = neg ? dtti_pkg::Int32Min : dtti_pkg::Int32Max;
      dtti_pkg::ModeU32: cap = dtti_pkg::Uint32Max;
      default:           cap = neg ? dtti_pkg::Int64Min : dtti_pkg::Int64Max;
    endcase

    prod     = ({4'd0, mag} << 3) + ({4'd0, mag} << 1) + {64'd0, ch_q[3:0]};
    prod_big = prod > {4'd0, cap};
    neg_mag  = 64'd0 - mag;

    case (mode_q)
      dtti_pkg::ModeS32: begin
        final_value = ovf ? cap : (neg ? {32'd0, neg_mag[31:0]} : mag);
      end
      dtti_pkg::ModeU32: begin
        if (ovf) begin
          final_value = neg ? 64'd1 : dtti_pkg::Uint32Max;
        end else begin
          final_value = neg ? {32'd0, neg_mag[31:0]} : mag;
        end
      end
      default: begin
        final_value = ovf ? cap : (neg ? neg_mag : mag);
      end
    endcase
  end

  always_comb begin
    phase_d  = phase_q;
    neg_d    = neg_q;
    mag_d    = mag_q;
    cons_d   = cons_q;
    ovf_d    = ovf_q;
    emit     = 1'b0;
    value_d  = final_value;
    status_d = ovf ? dtti_pkg::StRange : dtti_pkg::StOk;
    offset_d = cons;

    if (advance) begin
      phase_d = ph;
      neg_d   = neg;
      mag_d   = mag;
      cons_d  = cons;
      ovf_d   = ovf;
      case (ph)
        dtti_pkg::PhLead: begin
          if (is_digit) begin
            phase_d = dtti_pkg::PhDigits;
            cons_d  = cons_inc;
            if (!ovf) begin
              if (prod_big) begin
                ovf_d = 1'b1;
              end else begin
                mag_d = prod[63:0];
              end
            end
          end else if (!neg && is_space) begin
            cons_d = cons_inc;
          end else if (!neg && (ch_q == dtti_pkg::CharMinus)) begin
            neg_d  = 1'b1;
            cons_d = cons_inc;
          end else begin
            phase_d  = dtti_pkg::PhIdle;
            emit     = 1'b1;
            value_d  = 64'd0;
            status_d = dtti_pkg::StMalformed;
            offset_d = '0;
          end
        end
        dtti_pkg::PhDigits: begin
          if (is_digit) begin
            cons_d = cons_inc;
            if (!ovf) begin
              if (prod_big) begin
                ovf_d = 1'b1;
              end else begin
                mag_d = prod[63:0];
              end
            end
          end else begin
            phase_d = dtti_pkg::PhIdle;
            emit    = 1'b1;
          end
        end
        default: begin
          phase_d = dtti_pkg::PhIdle;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= dtti_pkg::ModeS32;
      in_valid_q  <= 1'b0;
      phase_q     <= dtti_pkg::PhIdle;
      neg_q       <= 1'b0;
      mag_q       <= 64'd0;
      cons_q      <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (result_mode_we_i) begin
        mode_q <= result_mode_i;
      end
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      phase_q <= phase_d;
      neg_q   <= neg_d;
      mag_q   <= mag_d;
      cons_q  <= cons_d;
      ovf_q   <= ovf_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      ch_q    <= ch_i;
      first_q <= first_i;
    end
    if (emit) begin
      value_q  <= value_d;
      status_q <= status_d;
      offset_q <= offset_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign value_o      = value_q;
  assign status_o     = status_q;
  assign end_offset_o = offset_q;

  // A malformed string reports neither a value nor an offset.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == dtti_pkg::StMalformed))
      |-> ((value_o == 64'd0) && (end_offset_o == '0)))
    else $error("malformed result carries a value or offset");

  // Each new result closes its string, so the parser is idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> (phase_q == dtti_pkg::PhIdle))
    else $error("result issued while the parser is still active");

  // Overflow is only raised by a digit, never before the first one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> (phase_q != dtti_pkg::PhLead))
    else $error("overflow flag set before any digit");

  // A stalled result is never overwritten by the next one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !emit)
    else $error("result register overwritten while stalled");

endmodule

`default_nettype wire

@@ tb/decimal_text_to_integer_test.sv @@
`timescale 1ns / 100ps

module decimal_text_to_integer_test;

  localparam int CycleLimit = 1_000_000;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharTab = 8'h09;
  localparam logic [7:0] CharCr = 8'h0D;
  localparam logic [7:0] CharEnd = 8'h3B;

  typedef struct packed {
    logic [63:0] value;
    logic [1:0] status;
    logic [dtti_pkg::OffsetWidth-1:0] offset;
  } conv_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic result_mode_we_i;
  logic [1:0] result_mode_i;
  logic in_valid_i;
  logic in_ready_o;
  logic [7:0] ch_i;
  logic first_i;
  logic out_valid_o;
  logic out_ready_i;
  logic [63:0] value_o;
  logic [1:0] status_o;
  logic [dtti_pkg::OffsetWidth-1:0] end_offset_o;

  decimal_text_to_integer u_top (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .result_mode_we_i(result_mode_we_i),
    .result_mode_i(result_mode_i),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .ch_i(ch_i),
    .first_i(first_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .value_o(value_o),
    .status_o(status_o),
    .end_offset_o(end_offset_o)
  );

  always #5 clk_i = ~clk_i;

  // Parser state as the block should hold it.
  logic [1:0] mode_q;
  logic [1:0] phase_q;
  logic neg_q;
  logic [63:0] mag_q;
  logic [dtti_pkg::OffsetWidth-1:0] count_q;
  logic ovf_q;

  conv_result_t pending_results[$];
  logic [7:0] text_q[$];
  int mismatches = 0;
  int cycle_count = 0;
  int text_chars = 0;
  int ready_hold = 0;
  bit no_gaps = 1'b0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [63:0] mode_limit(input logic neg);
    if (mode_q == dtti_pkg::ModeS32) return neg ? dtti_pkg::Int32Min : dtti_pkg::Int32Max;
    if (mode_q == dtti_pkg::ModeU32) return dtti_pkg::Uint32Max;
    return neg ? dtti_pkg::Int64Min : dtti_pkg::Int64Max;
  endfunction

  function automatic bit is_digit(input logic [7:0] c);
    return c >= dtti_pkg::CharZero && c <= dtti_pkg::CharNine;
  endfunction

  function automatic bit is_blank(input logic [7:0] c);
    return c == CharSpace || (c >= CharTab && c <= CharCr);
  endfunction

  task automatic bump_count();
    if (count_q != dtti_pkg::OffsetMax) count_q = count_q + 1'b1;
  endtask

  task automatic take_digit(input logic [7:0] c);
    logic [63:0] d;
    logic [63:0] cap;
    d = 64'(c) - 64'(dtti_pkg::CharZero);
    cap = mode_limit(neg_q);
    bump_count();
    if (!ovf_q) begin
      if (mag_q > (cap - d) / 64'd10) begin
        ovf_q = 1'b1;
      end else begin
        mag_q = mag_q * 64'd10 + d;
      end
    end
  endtask

  task automatic parse_char(input logic [7:0] c, input logic f);
    conv_result_t r;
    logic [63:0] v;
    if (f) begin
      phase_q = dtti_pkg::PhLead;
      neg_q = 1'b0;
      mag_q = '0;
      count_q = '0;
      ovf_q = 1'b0;
    end
    case (phase_q)
      dtti_pkg::PhLead: begin
        if (is_digit(c)) begin
          phase_q = dtti_pkg::PhDigits;
          take_digit(c);
        end else if (!neg_q && is_blank(c)) begin
          bump_count();
        end else if (!neg_q && c == dtti_pkg::CharMinus) begin
          neg_q = 1'b1;
          bump_count();
        end else begin
          phase_q = dtti_pkg::PhIdle;
          r = '{value: '0, status: dtti_pkg::StMalformed, offset: '0};
          pending_results.push_back(r);
        end
      end
      dtti_pkg::PhDigits: begin
        if (is_digit(c)) begin
          take_digit(c);
        end else begin
          phase_q = dtti_pkg::PhIdle;
          if (ovf_q) begin
            if (mode_q == dtti_pkg::ModeU32) begin
              v = neg_q ? 64'd1 : dtti_pkg::Uint32Max;
            end else begin
              v = mode_limit(neg_q);
            end
          end else if (!neg_q) begin
            v = mag_q;
          end else if (mode_q == dtti_pkg::ModeS32 || mode_q == dtti_pkg::ModeU32) begin
            v = {32'd0, 32'd0 - mag_q[31:0]};
          end else begin
            v = 64'd0 - mag_q;
          end
          r = '{value: v, status: ovf_q ? dtti_pkg::StRange : dtti_pkg::StOk,
                offset: count_q};
          pending_results.push_back(r);
        end
      end
      default: phase_q = dtti_pkg::PhIdle;
    endcase
  endtask

  // Leaves valid high after acceptance; drain_block, or a gap in the next call, lowers it.
  task automatic send_char(input logic [7:0] c, input logic f);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    ch_i <= c;
    first_i <= f;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (f || phase_q != dtti_pkg::PhIdle) text_chars++;
    parse_char(c, f);
  endtask

  task automatic send_text();
    foreach (text_q[i]) send_char(text_q[i], i == 0);
    text_q.delete();
  endtask

  task automatic add_str(input string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(8'(s[i]));
  endtask

  task automatic add_num(input logic [63:0] v);
    add_str($sformatf("%0d", v));
  endtask

  task automatic drain_block();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_mode(input logic [1:0] m);
    drain_block();
    result_mode_we_i <= 1'b1;
    result_mode_i <= m;
    @(posedge clk_i);
    result_mode_we_i <= 1'b0;
    mode_q = m;
  endtask

  task automatic add_blank();
    text_q.push_back($urandom_range(0, 5) == 5 ? CharSpace : 8'(CharTab + $urandom_range(0, 4)));
  endtask

  task automatic add_random_digits(input int len);
    repeat (len) text_q.push_back(8'(dtti_pkg::CharZero + $urandom_range(0, 9)));
  endtask

  function automatic logic [7:0] pick_nondigit();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (is_digit(c));
    return c;
  endfunction

  task automatic test_blanks_and_sign();
    set_mode(dtti_pkg::ModeS32);
    text_q = '{CharSpace, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
    add_str("-42;");
    send_text();
    add_str("7 ");
    send_text();
    add_str("0x");
    send_text();
    text_q = '{dtti_pkg::CharZero};
    text_q.push_back(8'hFF);
    send_text();
  endtask

  task automatic test_malformed();
    add_str("--5;");
    send_text();
    add_str("- 5;");
    send_text();
    add_str("x");
    send_text();
    add_str("-x");
    send_text();
    text_q = '{8'h0A, 8'h0A, 8'h00};
    send_text();
  endtask

  task automatic test_limits();
    logic [1:0] modes[4];
    modes = '{dtti_pkg::ModeS32, dtti_pkg::ModeU32, dtti_pkg::ModeS64,
              dtti_pkg::ModeS64Alias};
    foreach (modes[m]) begin
      set_mode(modes[m]);
      add_num(mode_limit(1'b0));
      add_str(";");
      send_text();
      add_num(mode_limit(1'b0) + 64'd1);
      add_str(" ");
      send_text();
      if (modes[m] != dtti_pkg::ModeS64Alias) begin
        add_str("-");
        add_num(mode_limit(1'b1));
        add_str(";");
        send_text();
        add_str("-");
        add_num(mode_limit(1'b1) + 64'd1);
        add_str("99;");
        send_text();
      end
    end
    set_mode(dtti_pkg::ModeU32);
    add_str("-5;");
    send_text();
  endtask

  task automatic test_leading_zeros();
    set_mode(dtti_pkg::ModeS32);
    add_str("0000000000000000000002147483647;");
    send_text();
    add_str("-000000000000002147483648 ");
    send_text();
  endtask

  task automatic test_idle_and_restart();
    send_char(8'h39, 1'b0);
    send_char(8'h2D, 1'b0);
    add_str("  -12");
    send_text();
    add_str("34;");
    send_text();
  endtask

  task automatic test_random_text(input logic [1:0] m, input int n_chars);
    int stop_at;
    int r;
    logic neg;
    logic [7:0] c;
    set_mode(m);
    stop_at = text_chars + n_chars;
    while (text_chars < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 75) begin
        repeat ($urandom_range(0, 2)) add_blank();
        neg = 1'($urandom_range(0, 1));
        if (neg) text_q.push_back(dtti_pkg::CharMinus);
        case ($urandom_range(0, 2))
          0: add_random_digits($urandom_range(1, 22));
          1: begin
            if ($urandom_range(0, 3) == 0) add_random_digits(0);
            repeat ($urandom_range(0, 2)) text_q.push_back(dtti_pkg::CharZero);
            add_num(mode_limit(neg) + 64'($urandom_range(0, 6)) - 64'd3);
          end
          default: begin
            repeat ($urandom_range(1, 6)) text_q.push_back(dtti_pkg::CharZero);
            add_random_digits($urandom_range(1, 4));
          end
        endcase
        text_q.push_back(pick_nondigit());
        send_text();
      end else if (r < 90) begin
        case ($urandom_range(0, 3))
          0: add_str("--");
          1: begin
            text_q.push_back(dtti_pkg::CharMinus);
            add_blank();
          end
          2: begin
            if ($urandom_range(0, 1)) text_q.push_back(dtti_pkg::CharMinus);
            do c = pick_nondigit(); while (is_blank(c) || c == dtti_pkg::CharMinus);
            text_q.push_back(c);
          end
          default: begin
            if ($urandom_range(0, 1)) text_q.push_back(dtti_pkg::CharMinus);
          end
        endcase
        add_random_digits($urandom_range(0, 3));
        send_text();
      end else begin
        repeat ($urandom_range(1, 4)) begin
          send_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end
      end
    end
    send_char(CharEnd, 1'b0);
  endtask

  task automatic report(input string field, input logic [63:0] exp_v, input logic [63:0] act_v);
    mismatches++;
    $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, field, exp_v, act_v);
  endtask

  always @(posedge clk_i) begin
    if (no_gaps) begin
      out_ready_i <= 1'b1;
    end else if (ready_hold > 0) begin
      out_ready_i <= 1'b0;
      ready_hold <= ready_hold - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      out_ready_i <= 1'b0;
      ready_hold <= pick_gap();
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    conv_result_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        report("unexpected request, value", 64'd0, value_o);
      end else begin
        e = pending_results.pop_front();
        if (value_o !== e.value) report("value", e.value, value_o);
        if (status_o !== e.status) report("status", 64'(e.status), 64'(status_o));
        if (end_offset_o !== e.offset) report("end_offset", 64'(e.offset), 64'(end_offset_o));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    result_mode_we_i = 1'b0;
    result_mode_i = dtti_pkg::ModeS32;
    in_valid_i = 1'b0;
    ch_i = '0;
    first_i = 1'b0;
    out_ready_i = 1'b0;
    mode_q = dtti_pkg::ModeS32;
    phase_q = dtti_pkg::PhIdle;
    neg_q = 1'b0;
    mag_q = '0;
    count_q = '0;
    ovf_q = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_blanks_and_sign();
    test_malformed();
    test_limits();
    test_leading_zeros();
    test_idle_and_restart();
    test_random_text(dtti_pkg::ModeS32, 100);
    test_random_text(dtti_pkg::ModeU32, 80);
    test_random_text(dtti_pkg::ModeS64, 100);
    no_gaps = 1'b1;
    test_random_text(dtti_pkg::ModeS32, 50);
    drain_block();
    no_gaps = 1'b0;

    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
